>>> src/rrm_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package rrm_pkg;

	localparam int VW = 32;                 // input component width
	localparam int NW = 32;                 // vector length (Q8.24) width
	localparam int UW = 32;                 // unit axis component width
	localparam int TW = 25;                 // threshold register width
	localparam int SCW = 34;                // working width of Q2.30 math
	localparam int OW = 32;                 // matrix entry width

	localparam int ISQ_STAGES = NW;         // one root bit per stage
	localparam int DIV_STAGES = UW - 1;     // one quotient bit per stage
	localparam int MOD_STAGES = 6;          // one power-of-two multiple of 2pi per stage
	localparam int FOLD_STAGES = 2;
	localparam int CORDIC_STAGES = 30;
	localparam int SC_LAT = MOD_STAGES + FOLD_STAGES + CORDIC_STAGES + 1;
	localparam int U_DELAY = SC_LAT - DIV_STAGES;
	localparam int MUL_STAGES = 3;
	localparam int PIPE_LAT = 2 + ISQ_STAGES + SC_LAT + MUL_STAGES;

	localparam logic signed [SCW-1:0] ONE_Q30 = 34'sd1073741824;
	localparam logic signed [SCW-1:0] PI_Q30 = 34'sd3373259426;
	localparam logic signed [SCW-1:0] TWO_PI_Q30 = 34'sd6746518852;
	localparam logic signed [SCW-1:0] HALF_PI_Q30 = 34'sd1686629713;
	localparam logic signed [SCW-1:0] GAIN_Q30 = 34'sd652032874;
	localparam logic signed [OW-1:0] ONE_OUT = 32'sd1073741824;
	localparam logic [TW-1:0] THRESH_RESET = 25'd2;

	typedef struct packed {
		logic [2*NW-1:0] rad;
		logic [NW+1:0] rem;
		logic [NW-1:0] root;
		logic [2:0][VW-1:0] mag;
		logic [2:0] neg;
	} isq_t;

	typedef struct packed {
		logic [NW-1:0] rem;
		logic [DIV_STAGES-1:0] low;
		logic [DIV_STAGES-1:0] q;
		logic [NW-1:0] d;
		logic neg;
	} div_t;

	typedef struct packed {
		logic signed [SCW-1:0] x;
		logic signed [SCW-1:0] y;
		logic signed [SCW-1:0] z;
		logic flip;
	} cordic_t;

	function automatic logic signed [SCW-1:0] atan_q30(input int i);
		logic [29:0] a;
		case (i)
			0: a = 30'h3243F6A8;
			1: a = 30'h1DAC6705;
			2: a = 30'h0FADBAFC;
			3: a = 30'h07F56EA6;
			4: a = 30'h03FEAB76;
			5: a = 30'h01FFD55B;
			6: a = 30'h00FFFAAA;
			7: a = 30'h007FFF55;
			8: a = 30'h003FFFEA;
			9: a = 30'h001FFFFD;
			10: a = 30'h000FFFFF;
			11: a = 30'h0007FFFF;
			12: a = 30'h0003FFFF;
			13: a = 30'h0001FFFF;
			14: a = 30'h0000FFFF;
			15: a = 30'h00007FFF;
			16: a = 30'h00003FFF;
			17: a = 30'h00001FFF;
			18: a = 30'h00000FFF;
			19: a = 30'h000007FF;
			20: a = 30'h000003FF;
			21: a = 30'h000001FF;
			22: a = 30'h000000FF;
			23: a = 30'h0000007F;
			24: a = 30'h0000003F;
			25: a = 30'h0000001F;
			26: a = 30'h0000000F;
			27: a = 30'h00000008;
			28: a = 30'h00000004;
			29: a = 30'h00000002;
			default: a = '0;
		endcase
		return SCW'(a);
	endfunction

	// Q2.30 product, floored back to Q2.30
	function automatic logic signed [SCW-1:0] mul30(input logic signed [SCW-1:0] a,
		input logic signed [SCW-1:0] b);
		logic signed [2*SCW-1:0] p;
		p = a * b;
		return p[SCW+29:30];
	endfunction

	function automatic logic signed [OW-1:0] sat32(input logic signed [SCW:0] v);
		if (v > 35'sd2147483647) begin
			return 32'sh7FFFFFFF;
		end else if (v < -35'sd2147483648) begin
			return 32'sh80000000;
		end
		return v[OW-1:0];
	endfunction

endpackage

`default_nettype wire

>>> src/axis_angle_to_rotation_matrix_core.sv
`timescale 1ns / 1ps
`default_nettype none

// Throughput: one vector per cycle; busy is never raised and nothing stalls.
// Depth is set by the bit-per-stage square root (32) and the 30-step CORDIC.
// Results cannot be held off: each is shown for one cycle with done.
// arst_n clears the valid pipeline and sets the threshold to 2.
module axis_angle_to_rotation_matrix_core (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	output logic                          busy,
	input  logic signed [rrm_pkg::VW-1:0] rot_vec_x,
	input  logic signed [rrm_pkg::VW-1:0] rot_vec_y,
	input  logic signed [rrm_pkg::VW-1:0] rot_vec_z,
	input  logic                          cfg_we,
	input  logic [rrm_pkg::TW-1:0]        cfg_wdata,
	output logic                          done,
	output logic signed [rrm_pkg::OW-1:0] m00,
	output logic signed [rrm_pkg::OW-1:0] m01,
	output logic signed [rrm_pkg::OW-1:0] m02,
	output logic signed [rrm_pkg::OW-1:0] m10,
	output logic signed [rrm_pkg::OW-1:0] m11,
	output logic signed [rrm_pkg::OW-1:0] m12,
	output logic signed [rrm_pkg::OW-1:0] m20,
	output logic signed [rrm_pkg::OW-1:0] m21,
	output logic signed [rrm_pkg::OW-1:0] m22
);
	import rrm_pkg::*;

	logic [TW-1:0] thr_q;
	logic [PIPE_LAT-1:0] vld_q;

	logic [2:0][VW-1:0] vin;
	logic [2:0][2*VW-1:0] sq_s1;
	logic [2:0][VW-1:0] mag_s1;
	logic [2:0] neg_s1;
	logic [2*NW-1:0] sum_s2;
	logic [2:0][VW-1:0] mag_s2;
	logic [2:0] neg_s2;

	isq_t isq_s [ISQ_STAGES];
	logic [NW-1:0] norm;

	logic [2:0][UW-1:0] quot;
	logic [2:0][UW-1:0] u_d [U_DELAY];
	logic [SC_LAT-1:0] id_d;
	logic signed [SCW-1:0] sin_val;
	logic signed [SCW-1:0] cos_val;
	logic signed [SCW-1:0] ue [3];

	logic signed [SCW-1:0] xy_p1, xz_p1, yz_p1, c_p1, t_p1;
	logic signed [SCW-1:0] sq_p1 [3];
	logic signed [SCW-1:0] us_p1 [3];
	logic id_p1;
	logic signed [SCW-1:0] xyt_p2, xzt_p2, yzt_p2;
	logic signed [SCW-1:0] sq_p2 [3];
	logic signed [SCW-1:0] us_p2 [3];
	logic signed [SCW-1:0] dg_p2 [3];
	logic id_p2;
	logic signed [OW-1:0] ent [9];

	assign busy = 1'b0;
	assign done = vld_q[PIPE_LAT-1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			thr_q <= THRESH_RESET;
			vld_q <= '0;
		end else begin
			if (cfg_we) begin
				thr_q <= cfg_wdata;
			end
			vld_q <= {vld_q[PIPE_LAT-2:0], start};
		end
	end

	// squares of the component magnitudes
	assign vin = {rot_vec_z, rot_vec_y, rot_vec_x};

	always_ff @(posedge clk) begin
		for (int i = 0; i < 3; i++) begin
			logic [VW-1:0] m;
			m = vin[i][VW-1] ? -vin[i] : vin[i];
			mag_s1[i] <= m;
			neg_s1[i] <= vin[i][VW-1];
			sq_s1[i] <= m * m;
		end
	end

	always_ff @(posedge clk) begin
		sum_s2 <= sq_s1[0] + sq_s1[1] + sq_s1[2];
		mag_s2 <= mag_s1;
		neg_s2 <= neg_s1;
	end

	// integer square root, one root bit per stage
	for (genvar k = 0; k < ISQ_STAGES; k++) begin : g_isq
		isq_t cur;
		isq_t nxt;
		logic [NW+3:0] acc;
		logic [NW+3:0] trial;

		if (k == 0) begin : g_first
			always_comb begin
				cur = '0;
				cur.rad = sum_s2;
				cur.mag = mag_s2;
				cur.neg = neg_s2;
			end
		end else begin : g_next
			assign cur = isq_s[k-1];
		end

		always_comb begin
			acc = {cur.rem, cur.rad[2*NW-1:2*NW-2]};
			trial = {2'b00, cur.root, 2'b01};
			nxt = cur;
			nxt.rad = {cur.rad[2*NW-3:0], 2'b00};
			if (acc >= trial) begin
				nxt.rem = (NW+2)'(acc - trial);
				nxt.root = {cur.root[NW-2:0], 1'b1};
			end else begin
				nxt.rem = acc[NW+1:0];
				nxt.root = {cur.root[NW-2:0], 1'b0};
			end
		end

		always_ff @(posedge clk) begin
			isq_s[k] <= nxt;
		end
	end

	assign norm = isq_s[ISQ_STAGES-1].root;

	for (genvar i = 0; i < 3; i++) begin : g_axis
		rrm_div u_div (
			.clk     (clk),
			.divisor (norm),
			.mag     (isq_s[ISQ_STAGES-1].mag[i]),
			.neg     (isq_s[ISQ_STAGES-1].neg[i]),
			.quot    (quot[i])
		);
	end

	rrm_sincos u_sincos (
		.clk     (clk),
		.norm    (norm),
		.sin_val (sin_val),
		.cos_val (cos_val)
	);

	// zero length or below threshold: identity; divider output is ignored then
	always_ff @(posedge clk) begin
		id_d <= {id_d[SC_LAT-2:0], (norm == '0) || (norm < NW'(thr_q))};
		u_d[0] <= quot;
		for (int k = 1; k < U_DELAY; k++) begin
			u_d[k] <= u_d[k-1];
		end
	end

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			ue[i] = SCW'($signed(u_d[U_DELAY-1][i]));
		end
	end

	always_ff @(posedge clk) begin
		xy_p1 <= mul30(ue[0], ue[1]);
		xz_p1 <= mul30(ue[0], ue[2]);
		yz_p1 <= mul30(ue[1], ue[2]);
		for (int i = 0; i < 3; i++) begin
			sq_p1[i] <= mul30(ue[i], ue[i]);
			us_p1[i] <= mul30(ue[i], sin_val);
		end
		c_p1 <= cos_val;
		t_p1 <= ONE_Q30 - cos_val;
		id_p1 <= id_d[SC_LAT-1];
	end

	always_ff @(posedge clk) begin
		xyt_p2 <= mul30(xy_p1, t_p1);
		xzt_p2 <= mul30(xz_p1, t_p1);
		yzt_p2 <= mul30(yz_p1, t_p1);
		for (int i = 0; i < 3; i++) begin
			dg_p2[i] <= mul30(ONE_Q30 - sq_p1[i], c_p1);
			sq_p2[i] <= sq_p1[i];
			us_p2[i] <= us_p1[i];
		end
		id_p2 <= id_p1;
	end

	always_comb begin
		ent[0] = sat32((SCW+1)'(sq_p2[0]) + (SCW+1)'(dg_p2[0]));
		ent[1] = sat32((SCW+1)'(xyt_p2) - (SCW+1)'(us_p2[2]));
		ent[2] = sat32((SCW+1)'(xzt_p2) + (SCW+1)'(us_p2[1]));
		ent[3] = sat32((SCW+1)'(xyt_p2) + (SCW+1)'(us_p2[2]));
		ent[4] = sat32((SCW+1)'(sq_p2[1]) + (SCW+1)'(dg_p2[1]));
		ent[5] = sat32((SCW+1)'(yzt_p2) - (SCW+1)'(us_p2[0]));
		ent[6] = sat32((SCW+1)'(xzt_p2) - (SCW+1)'(us_p2[1]));
		ent[7] = sat32((SCW+1)'(yzt_p2) + (SCW+1)'(us_p2[0]));
		ent[8] = sat32((SCW+1)'(sq_p2[2]) + (SCW+1)'(dg_p2[2]));
		if (id_p2) begin
			for (int i = 0; i < 9; i++) begin
				ent[i] = '0;
			end
			ent[0] = ONE_OUT;
			ent[4] = ONE_OUT;
			ent[8] = ONE_OUT;
		end
	end

	always_ff @(posedge clk) begin
		m00 <= ent[0];
		m01 <= ent[1];
		m02 <= ent[2];
		m10 <= ent[3];
		m11 <= ent[4];
		m12 <= ent[5];
		m20 <= ent[6];
		m21 <= ent[7];
		m22 <= ent[8];
	end

	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		start |-> ##PIPE_LAT done)
		else $error("transfer did not produce a result on time");

	a_no_spurious: assert property (@(posedge clk) disable iff (!arst_n)
		!start |-> ##PIPE_LAT !done)
		else $error("result without a matching transfer");

	a_identity: assert property (@(posedge clk) disable iff (!arst_n)
		(done && $past(id_p2)) |-> (m00 == ONE_OUT && m11 == ONE_OUT && m22 == ONE_OUT
			&& m01 == '0 && m12 == '0 && m20 == '0))
		else $error("small angle result is not the identity");

endmodule

`default_nettype wire

>>> src/rrm_div.sv
`timescale 1ns / 1ps
`default_nettype none

module rrm_div (
	input  logic                          clk,
	input  logic [rrm_pkg::NW-1:0]        divisor,
	input  logic [rrm_pkg::VW-1:0]        mag,
	input  logic                          neg,
	output logic signed [rrm_pkg::UW-1:0] quot
);
	import rrm_pkg::*;

	div_t div_s [DIV_STAGES];
	logic [UW-1:0] q_ext;

	// mag <= divisor, so the quotient needs only DIV_STAGES bits and the
	// upper dividend bits (mag >> 1) already sit below the divisor
	for (genvar k = 0; k < DIV_STAGES; k++) begin : g_div
		div_t cur;
		div_t nxt;
		logic [NW:0] acc;

		if (k == 0) begin : g_first
			always_comb begin
				cur = '0;
				cur.rem = {1'b0, mag[VW-1:1]};
				cur.low = {mag[0], {(DIV_STAGES-1){1'b0}}};
				cur.d = divisor;
				cur.neg = neg;
			end
		end else begin : g_next
			assign cur = div_s[k-1];
		end

		always_comb begin
			acc = {cur.rem, cur.low[DIV_STAGES-1]};
			nxt = cur;
			nxt.low = {cur.low[DIV_STAGES-2:0], 1'b0};
			if (acc >= {1'b0, cur.d}) begin
				nxt.rem = NW'(acc - {1'b0, cur.d});
				nxt.q = {cur.q[DIV_STAGES-2:0], 1'b1};
			end else begin
				nxt.rem = acc[NW-1:0];
				nxt.q = {cur.q[DIV_STAGES-2:0], 1'b0};
			end
		end

		always_ff @(posedge clk) begin
			div_s[k] <= nxt;
		end
	end

	assign q_ext = {1'b0, div_s[DIV_STAGES-1].q};
	assign quot = div_s[DIV_STAGES-1].neg ? $signed(-q_ext) : $signed(q_ext);

endmodule

`default_nettype wire

>>> src/rrm_sincos.sv
`timescale 1ns / 1ps
`default_nettype none

module rrm_sincos (
	input  logic                           clk,
	input  logic [rrm_pkg::NW-1:0]         norm,
	output logic signed [rrm_pkg::SCW-1:0] sin_val,
	output logic signed [rrm_pkg::SCW-1:0] cos_val
);
	import rrm_pkg::*;

	localparam int AW = NW + 6;

	logic [AW-1:0] red_s [MOD_STAGES];
	logic signed [SCW-1:0] r1_s;
	logic signed [SCW-1:0] z0_s;
	logic fl0_s;
	cordic_t cor_s [CORDIC_STAGES];

	// Q8.24 -> Q2.30, then strip multiples of 2pi, largest first
	for (genvar k = 0; k < MOD_STAGES; k++) begin : g_mod
		localparam logic [AW-1:0] STEP = AW'(TWO_PI_Q30) << (MOD_STAGES - 1 - k);
		logic [AW-1:0] cur;

		if (k == 0) begin : g_first
			assign cur = {norm, 6'b000000};
		end else begin : g_next
			assign cur = red_s[k-1];
		end

		always_ff @(posedge clk) begin
			if (cur >= STEP) begin
				red_s[k] <= cur - STEP;
			end else begin
				red_s[k] <= cur;
			end
		end
	end

	always_ff @(posedge clk) begin
		logic signed [SCW-1:0] r;
		r = $signed({1'b0, red_s[MOD_STAGES-1][SCW-2:0]});
		if (r > PI_Q30) begin
			r1_s <= r - TWO_PI_Q30;
		end else begin
			r1_s <= r;
		end
	end

	// fold into +-pi/2; a folded angle's result is negated at the end
	always_ff @(posedge clk) begin
		if (r1_s > HALF_PI_Q30) begin
			z0_s <= r1_s - PI_Q30;
			fl0_s <= 1'b1;
		end else if (r1_s < -HALF_PI_Q30) begin
			z0_s <= r1_s + PI_Q30;
			fl0_s <= 1'b1;
		end else begin
			z0_s <= r1_s;
			fl0_s <= 1'b0;
		end
	end

	for (genvar i = 0; i < CORDIC_STAGES; i++) begin : g_cordic
		localparam logic signed [SCW-1:0] ATAN = atan_q30(i);
		cordic_t cur;
		cordic_t nxt;
		logic signed [SCW-1:0] dx;
		logic signed [SCW-1:0] dy;

		if (i == 0) begin : g_first
			always_comb begin
				cur.x = GAIN_Q30;
				cur.y = '0;
				cur.z = z0_s;
				cur.flip = fl0_s;
			end
		end else begin : g_next
			assign cur = cor_s[i-1];
		end

		always_comb begin
			dx = cur.y >>> i;
			dy = cur.x >>> i;
			nxt = cur;
			if (cur.z >= 0) begin
				nxt.x = cur.x - dx;
				nxt.y = cur.y + dy;
				nxt.z = cur.z - ATAN;
			end else begin
				nxt.x = cur.x + dx;
				nxt.y = cur.y - dy;
				nxt.z = cur.z + ATAN;
			end
		end

		always_ff @(posedge clk) begin
			cor_s[i] <= nxt;
		end
	end

	always_ff @(posedge clk) begin
		if (cor_s[CORDIC_STAGES-1].flip) begin
			cos_val <= -cor_s[CORDIC_STAGES-1].x;
			sin_val <= -cor_s[CORDIC_STAGES-1].y;
		end else begin
			cos_val <= cor_s[CORDIC_STAGES-1].x;
			sin_val <= cor_s[CORDIC_STAGES-1].y;
		end
	end

endmodule

`default_nettype wire
